@@ hw/rtl/m3inv_pkg.sv @@
// ----------------------------------------------------------------------------
// m3inv_pkg
// shared types and constants for the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package m3inv_pkg;

    localparam int ELEM_W   = 32;               // q16.16 element
    localparam int CF_W     = 66;               // cofactor, 2^-32 scale
    localparam int DET_W    = 100;              // determinant, 2^-48 scale
    localparam int NUM_W    = CF_W + 32;        // |cofactor| * 2^32
    localparam int DIV_Q_W  = 32;               // quotient bits developed
    localparam int DIV_R_W  = DET_W + DIV_Q_W;  // remainder width
    localparam int DIV_LAT  = DIV_Q_W + 1;      // overflow check plus one bit a stage
    localparam int FRONT_LAT = 5;               // products .. abs values
    localparam int LAT      = FRONT_LAT + DIV_LAT + 1;

    localparam logic [DIV_Q_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [DIV_Q_W-1:0] NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } in_item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv00;
        logic signed [ELEM_W-1:0] inv01;
        logic signed [ELEM_W-1:0] inv02;
        logic signed [ELEM_W-1:0] inv10;
        logic signed [ELEM_W-1:0] inv11;
        logic signed [ELEM_W-1:0] inv12;
        logic signed [ELEM_W-1:0] inv20;
        logic signed [ELEM_W-1:0] inv21;
        logic signed [ELEM_W-1:0] inv22;
        logic                     singular;
        logic                     saturated;
    } out_item_t;

    // divider result travelling to the output stage
    typedef struct packed {
        logic [DIV_Q_W-1:0] q;
        logic               neg;
        logic               ovf;
    } div_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/m3inv_div.sv @@
// ----------------------------------------------------------------------------
// m3inv_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m3inv_div
    import m3inv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DET_W-1:0]   den,
    input  wire logic               neg,
    output div_res_t                res
);

    logic [DIV_R_W-1:0] r_reg   [DIV_Q_W+1];
    logic [DIV_R_W-1:0] r_next  [DIV_Q_W+1];
    logic [DET_W-1:0]   d_reg   [DIV_Q_W+1];
    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W+1];
    logic [DIV_Q_W-1:0] q_next  [DIV_Q_W+1];
    logic               neg_reg [DIV_Q_W+1];
    logic               ovf_reg [DIV_Q_W+1];
    logic               ovf_next;

    always_comb
    begin
        logic [DIV_R_W-1:0] dsh;
        logic               qb;
        r_next[0] = DIV_R_W'(num);
        q_next[0] = '0;
        // quotient of 2^32 or more always saturates
        ovf_next  = DIV_R_W'(num) >= (DIV_R_W'(den) << DIV_Q_W);
        for (int k = 1; k <= DIV_Q_W; k++)
        begin
            dsh = DIV_R_W'(d_reg[k-1]) << (DIV_Q_W - k);
            qb  = r_reg[k-1] >= dsh;
            r_next[k] = qb ? r_reg[k-1] - dsh : r_reg[k-1];
            q_next[k] = {q_reg[k-1][DIV_Q_W-2:0], qb};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= r_next[0];
            q_reg[0]   <= q_next[0];
            d_reg[0]   <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
            for (int k = 1; k <= DIV_Q_W; k++)
            begin
                r_reg[k]   <= r_next[k];
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign res.q   = q_reg[DIV_Q_W];
    assign res.neg = neg_reg[DIV_Q_W];
    assign res.ovf = ovf_reg[DIV_Q_W];

endmodule

`default_nettype wire

@@ hw/rtl/matrix3_inverse_unit.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// 3x3 matrix inverse of signed q16.16 elements by the adjugate
// ----------------------------------------------------------------------------
// One item in, one item out, a new matrix every cycle unless held. There are
// five front stages (element products, cofactors, split determinant products,
// determinant sum, magnitudes and signs), 33 divider stages (one overflow
// check then one quotient bit per stage, nine dividers side by side) and an
// output register. The whole pipe advances together; it holds only while a
// finished item waits at the output under stall, so in_stall follows
// out_valid and out_stall. A zero determinant gives all-zero elements with
// singular set; an element beyond 32 bits is clamped and raises saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_unit
    import m3inv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_item
);

    logic en;
    logic vld_reg [LAT];

    // stage 1: the eighteen element products
    logic signed [ELEM_W-1:0]   m [9];
    logic signed [2*ELEM_W-1:0] p_reg [18];
    logic signed [ELEM_W-1:0]   m0_s1_reg [3];

    // stage 2: cofactors, cf[3*row+col]
    logic signed [CF_W-1:0]     cf_s2_reg [9];
    logic signed [CF_W-1:0]     cf_next   [9];
    logic signed [ELEM_W-1:0]   m0_s2_reg [3];

    // stage 3: determinant partial products, cofactor split at bit 32
    logic signed [ELEM_W+32:0]  pl_reg [3];
    logic signed [CF_W+31:0]    ph_reg [3];
    logic signed [CF_W-1:0]     cf_s3_reg [9];

    // stage 4: determinant
    logic signed [DET_W-1:0]    det_reg;
    logic signed [DET_W-1:0]    det_next;
    logic signed [CF_W-1:0]     cf_s4_reg [9];

    // stage 5: magnitudes and signs
    logic [NUM_W-1:0]           num_reg [9];
    logic [DET_W-1:0]           den_reg;
    logic                       neg_reg [9];
    logic                       sing_reg;

    logic                       sing_pipe_reg [DIV_LAT];
    div_res_t                   dres [9];
    out_item_t                  out_item_reg;
    out_item_t                  out_item_next;
    logic signed [ELEM_W-1:0]   val [9];
    logic                       sat_any;

    // pipe moves unless the output item is held
    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = vld_reg[LAT-1] && out_stall;
    assign out_valid = vld_reg[LAT-1];
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign m[0] = in_item.m00;
    assign m[1] = in_item.m01;
    assign m[2] = in_item.m02;
    assign m[3] = in_item.m10;
    assign m[4] = in_item.m11;
    assign m[5] = in_item.m12;
    assign m[6] = in_item.m20;
    assign m[7] = in_item.m21;
    assign m[8] = in_item.m22;

    // cofactor k is p[2k] - p[2k+1], negated on the odd checkerboard places
    always_comb
    begin
        logic signed [CF_W-2:0] df;
        for (int k = 0; k < 9; k++)
        begin
            df = (CF_W-1)'(p_reg[2*k]) - (CF_W-1)'(p_reg[2*k+1]);
            cf_next[k] = (k % 2 == 1) ? -CF_W'(df) : CF_W'(df);
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
            det_next = det_next + (DET_W'(ph_reg[j]) <<< 32) + DET_W'(pl_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            p_reg[0]  <= m[4] * m[8];  p_reg[1]  <= m[7] * m[5];
            p_reg[2]  <= m[3] * m[8];  p_reg[3]  <= m[6] * m[5];
            p_reg[4]  <= m[3] * m[7];  p_reg[5]  <= m[6] * m[4];
            p_reg[6]  <= m[1] * m[8];  p_reg[7]  <= m[7] * m[2];
            p_reg[8]  <= m[0] * m[8];  p_reg[9]  <= m[6] * m[2];
            p_reg[10] <= m[0] * m[7];  p_reg[11] <= m[6] * m[1];
            p_reg[12] <= m[1] * m[5];  p_reg[13] <= m[2] * m[4];
            p_reg[14] <= m[0] * m[5];  p_reg[15] <= m[3] * m[2];
            p_reg[16] <= m[0] * m[4];  p_reg[17] <= m[1] * m[3];
            for (int j = 0; j < 3; j++)
                m0_s1_reg[j] <= m[j];
            // stage 2
            for (int k = 0; k < 9; k++)
                cf_s2_reg[k] <= cf_next[k];
            m0_s2_reg <= m0_s1_reg;
            // stage 3
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= m0_s2_reg[j] * $signed({1'b0, cf_s2_reg[j][31:0]});
                ph_reg[j] <= m0_s2_reg[j] * $signed(cf_s2_reg[j][CF_W-1:32]);
            end
            cf_s3_reg <= cf_s2_reg;
            // stage 4
            det_reg   <= det_next;
            cf_s4_reg <= cf_s3_reg;
            // stage 5: element (i,j) takes cofactor (j,i)
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    num_reg[3*i+j] <= {(cf_s4_reg[3*j+i][CF_W-1]
                                        ? CF_W'(-cf_s4_reg[3*j+i])
                                        : CF_W'(cf_s4_reg[3*j+i])), 32'b0};
                    neg_reg[3*i+j] <= cf_s4_reg[3*j+i][CF_W-1] ^ det_reg[DET_W-1];
                end
            end
            den_reg  <= det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
            sing_reg <= (det_reg == '0);
            // singular flag alongside the dividers
            sing_pipe_reg[0] <= sing_reg;
            for (int s = 1; s < DIV_LAT; s++)
                sing_pipe_reg[s] <= sing_pipe_reg[s-1];
            out_item_reg <= out_item_next;
        end
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_div
        m3inv_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[g]),
            .den (den_reg),
            .neg (neg_reg[g]),
            .res (dres[g])
        );
    end

    // sign, clamp and the singular override
    always_comb
    begin
        logic clip;
        sat_any = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            clip = dres[k].ovf || (dres[k].neg ? (dres[k].q > NEG_LIM)
                                               : (dres[k].q > POS_LIM));
            if (clip)
                val[k] = dres[k].neg ? NEG_LIM : POS_LIM;
            else
                val[k] = dres[k].neg ? -dres[k].q : dres[k].q;
            sat_any = sat_any | clip;
        end
        if (sing_pipe_reg[DIV_LAT-1])
        begin
            out_item_next           = '0;
            out_item_next.singular  = 1'b1;
        end
        else
        begin
            out_item_next.inv00     = val[0];
            out_item_next.inv01     = val[1];
            out_item_next.inv02     = val[2];
            out_item_next.inv10     = val[3];
            out_item_next.inv11     = val[4];
            out_item_next.inv12     = val[5];
            out_item_next.inv20     = val[6];
            out_item_next.inv21     = val[7];
            out_item_next.inv22     = val[8];
            out_item_next.singular  = 1'b0;
            out_item_next.saturated = sat_any;
        end
    end

    // the front only stalls behind a held output item
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output item");

    // a held output item stays put for the next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("held output item changed");

    // singular results carry no clamp and zero elements
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.singular) |->
            (!out_item.saturated && out_item.inv00 == '0 && out_item.inv22 == '0))
        else $error("singular item with non-zero payload");

endmodule

`default_nettype wire
